/* rtl/core/urlpd_pkg.sv */
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types, constants and helpers for the percent-decoder with UTF-8
// code point assembly.
// ----------------------------------------------------------------------------
package urlpd_pkg;

  localparam int unsigned ChW     = 21;
  localparam int unsigned PosW    = 5;
  localparam int unsigned TdataW  = 24;

  localparam logic [ChW-1:0] ChPercent = 21'h25;
  localparam logic [ChW-1:0] ChPlus    = 21'h2B;
  localparam logic [ChW-1:0] ChSpace   = 21'h20;
  localparam logic [ChW-1:0] ChNine    = 21'h39;

  // sequence position codes; 3..17 count remaining continuation characters
  localparam logic [PosW-1:0] SEQ_IDLE = 5'd0;
  localparam logic [PosW-1:0] SEQ_HI   = 5'd1;
  localparam logic [PosW-1:0] SEQ_LO   = 5'd2;
  localparam logic [PosW-1:0] SEQ_LAST = 5'd3;
  localparam logic [PosW-1:0] SEQ_MAX  = 5'd17;
  localparam logic [PosW-1:0] SEQ_G1   = 5'd5;
  localparam logic [PosW-1:0] SEQ_G2   = 5'd8;
  localparam logic [PosW-1:0] SEQ_G3   = 5'd11;
  localparam logic [PosW-1:0] SEQ_G4   = 5'd14;
  localparam logic [PosW-1:0] SEQ_G5   = 5'd17;

  // slot within a continuation group
  localparam logic [1:0] SLOT_PCT = 2'd0;
  localparam logic [1:0] SLOT_LO  = 2'd1;
  localparam logic [1:0] SLOT_HI  = 2'd2;

  typedef struct packed {
    logic [ChW-1:0] code_point;
    logic           bad_lead;
  } result_t;

  function automatic logic [3:0] hex_nibble(input logic [ChW-1:0] c);
    logic [3:0] v;
    if (c > ChNine) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = c[3:0];
    end
    return v;
  endfunction

  function automatic logic [1:0] group_slot(input logic [PosW-1:0] pos);
    logic [1:0] s;
    unique case (pos)
      5'd3, 5'd6, 5'd9,  5'd12, 5'd15: s = SLOT_LO;
      5'd4, 5'd7, 5'd10, 5'd13, 5'd16: s = SLOT_HI;
      default:                         s = SLOT_PCT;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/urlpd_step.sv */
// ----------------------------------------------------------------------------
// urlpd_step
// Per-character decode: sequence state registers and the update logic that
// turns one registered character into at most one result.
// ----------------------------------------------------------------------------
module urlpd_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [urlpd_pkg::ChW-1:0]  ch_i,
  input  logic                       eos_i,
  output logic                       emit_o,
  output urlpd_pkg::result_t         result_o
);

  logic [urlpd_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]                 lead_q, lead_d;
  logic [3:0]                 nib_q, nib_d;
  logic [urlpd_pkg::ChW-1:0]  acc_q, acc_d;
  logic [3:0]                 hex;
  logic [7:0]                 byte_v;
  logic [1:0]                 slot;

  assign hex    = urlpd_pkg::hex_nibble(ch_i);
  assign byte_v = {nib_q, hex};
  assign slot   = urlpd_pkg::group_slot(pos_q);

  always_comb begin
    pos_d    = pos_q;
    lead_d   = lead_q;
    nib_d    = nib_q;
    acc_d    = acc_q;
    emit_o   = 1'b0;
    result_o = '0;

    if (pos_q == urlpd_pkg::SEQ_HI) begin
      nib_d = hex;
      pos_d = urlpd_pkg::SEQ_LO;
    end else if (pos_q == urlpd_pkg::SEQ_LO) begin
      lead_d = byte_v;
      priority if (byte_v[7:2] == 6'h3F) begin
        acc_d = '0;
        pos_d = urlpd_pkg::SEQ_G5;
      end else if (byte_v[7:3] == 5'h1F) begin
        acc_d = '0;
        pos_d = urlpd_pkg::SEQ_G4;
      end else if (byte_v[7:4] == 4'hF) begin
        acc_d = {18'd0, byte_v[2:0]};
        pos_d = urlpd_pkg::SEQ_G3;
      end else if (byte_v[7:5] == 3'h7) begin
        acc_d = {17'd0, byte_v[3:0]};
        pos_d = urlpd_pkg::SEQ_G2;
      end else if (byte_v[7:6] == 2'h3) begin
        acc_d = {16'd0, byte_v[4:0]};
        pos_d = urlpd_pkg::SEQ_G1;
      end else begin
        emit_o              = 1'b1;
        result_o.code_point = {13'd0, byte_v};
        pos_d               = urlpd_pkg::SEQ_IDLE;
      end
    end else if (pos_q >= urlpd_pkg::SEQ_LAST && pos_q <= urlpd_pkg::SEQ_MAX) begin
      if (slot == urlpd_pkg::SLOT_HI) begin
        nib_d = hex;
      end else if (slot == urlpd_pkg::SLOT_LO) begin
        acc_d = {acc_q[14:0], byte_v[5:0]};
      end
      if (pos_q == urlpd_pkg::SEQ_LAST) begin
        pos_d  = urlpd_pkg::SEQ_IDLE;
        emit_o = 1'b1;
        if (lead_q[7:3] == 5'h1F) begin
          result_o.bad_lead = 1'b1;
        end else begin
          result_o.code_point = acc_d;
        end
      end else begin
        pos_d = pos_q - 5'd1;
      end
    end else begin
      pos_d = urlpd_pkg::SEQ_IDLE;
      if (ch_i == urlpd_pkg::ChPercent) begin
        pos_d = urlpd_pkg::SEQ_HI;
      end else if (ch_i == urlpd_pkg::ChPlus) begin
        emit_o              = 1'b1;
        result_o.code_point = urlpd_pkg::ChSpace;
      end else begin
        emit_o              = 1'b1;
        result_o.code_point = ch_i;
      end
    end

    if (eos_i) begin
      pos_d  = urlpd_pkg::SEQ_IDLE;
      lead_d = '0;
      nib_d  = '0;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= urlpd_pkg::SEQ_IDLE;
      lead_q <= '0;
      nib_q  <= '0;
      acc_q  <= '0;
    end else if (advance_i) begin
      pos_q  <= pos_d;
      lead_q <= lead_d;
      nib_q  <= nib_d;
      acc_q  <= acc_d;
    end
  end

endmodule

/* rtl/core/urlpd_out_reg.sv */
// ----------------------------------------------------------------------------
// urlpd_out_reg
// Result register on the master side; holds a result until it is taken.
// ----------------------------------------------------------------------------
module urlpd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  urlpd_pkg::result_t  result_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output urlpd_pkg::result_t  result_o
);

  logic               vld_q, vld_d;
  urlpd_pkg::result_t res_q;

  assign room_o  = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign result_o = res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

/* rtl/core/url_percent_utf8_decoder_core.sv */
// ----------------------------------------------------------------------------
// url_percent_utf8_decoder_core
// Percent-decoder for one character per item with UTF-8 code point assembly.
// ----------------------------------------------------------------------------
// One character enters per cycle while the output is not stalled; it is held
// in the input register and its result in the result register. The block
// sustains one item per cycle under that condition; the rate is set by the
// single update of the sequence state, which each character passes once. A
// character that only opens or continues a percent sequence gives no result;
// the code point appears with the character that completes it. tlast on the
// input drops any unfinished sequence after that character is handled.
module url_percent_utf8_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [20:0] ch, [23:21] zero
  input  logic        s_axis_tlast_i,  // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [20:0] code_point, [23:21] zero
  output logic        m_axis_tuser_o   // bad_lead
);

  logic                      in_vld_q, in_vld_d;
  logic [urlpd_pkg::ChW-1:0] in_ch_q;
  logic                      in_eos_q;
  logic                      advance;
  logic                      out_room;
  logic                      emit;
  logic                      s_take;
  urlpd_pkg::result_t        step_res;
  urlpd_pkg::result_t        out_res;

  assign advance         = in_vld_q && out_room;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_ch_q  <= s_axis_tdata_i[urlpd_pkg::ChW-1:0];
      in_eos_q <= s_axis_tlast_i;
    end
  end

  urlpd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .ch_i      (in_ch_q),
    .eos_i     (in_eos_q),
    .emit_o    (emit),
    .result_o  (step_res)
  );

  urlpd_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (step_res),
    .room_o   (out_room),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {3'd0, out_res.code_point};
  assign m_axis_tuser_o = out_res.bad_lead;

  a_bad_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 24'd0))
    else $error("bad_lead result carries a nonzero code point");

  a_take_frees_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_take |-> (!in_vld_q || advance))
    else $error("item taken while input register is occupied");

  a_hold_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_ch_q) && $stable(in_eos_q)))
    else $error("stalled input item changed");

endmodule

/* tb/sv/urlpd_checker.sv */
// ----------------------------------------------------------------------------
// urlpd_checker
// Watches both streams of the percent decoder, predicts the decoded code
// points from the accepted characters and compares every accepted result,
// oldest first.
// ----------------------------------------------------------------------------
module urlpd_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [urlpd_pkg::TdataW-1:0] s_tdata_i,
  input  logic                         s_tlast_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [urlpd_pkg::TdataW-1:0] m_tdata_i,
  input  logic                         m_tuser_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o,
  output int unsigned                  bad_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [urlpd_pkg::PosW-1:0] pos;
  logic [7:0]                 lead;
  logic [3:0]                 hi_nib;
  logic [urlpd_pkg::ChW-1:0]  accum;

  urlpd_pkg::result_t         code_point_q[$];
  bit                         got_one;
  urlpd_pkg::result_t         next_res;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    bad_count_o  = 0;
  end

  function automatic logic [3:0] digit_value(input logic [urlpd_pkg::ChW-1:0] c);
    logic [31:0] v;
    if (c > 21'h39) begin
      v = (c < 21'h61) ? 32'(c) - 32'h37 : 32'(c) - 32'h57;
    end else begin
      v = 32'(c);
    end
    return v[3:0];
  endfunction

  task automatic decode_char(input logic [urlpd_pkg::ChW-1:0] c, input logic last,
                             output bit emit, output urlpd_pkg::result_t res);
    int unsigned groups;
    int unsigned remain;
    logic [7:0]  b;
    emit = 1'b0;
    res  = '0;
    if (pos == urlpd_pkg::SEQ_HI) begin
      hi_nib = digit_value(c);
      pos    = urlpd_pkg::SEQ_LO;
    end else if (pos == urlpd_pkg::SEQ_LO) begin
      lead = {hi_nib, digit_value(c)};
      if (lead[7:2] == 6'h3F) begin
        groups = 5;
        accum  = '0;
      end else if (lead[7:3] == 5'h1F) begin
        groups = 4;
        accum  = '0;
      end else if (lead[7:4] == 4'hF) begin
        groups = 3;
        accum  = urlpd_pkg::ChW'(lead[2:0]);
      end else if (lead[7:5] == 3'h7) begin
        groups = 2;
        accum  = urlpd_pkg::ChW'(lead[3:0]);
      end else if (lead[7:6] == 2'h3) begin
        groups = 1;
        accum  = urlpd_pkg::ChW'(lead[4:0]);
      end else begin
        groups = 0;
      end
      if (groups == 0) begin
        emit           = 1'b1;
        res.code_point = urlpd_pkg::ChW'(lead);
        pos            = urlpd_pkg::SEQ_IDLE;
      end else begin
        pos = urlpd_pkg::SEQ_LO + urlpd_pkg::PosW'(3 * groups);
      end
    end else if (pos >= urlpd_pkg::SEQ_LAST && pos <= urlpd_pkg::SEQ_MAX) begin
      remain = pos - 2;
      case (2'(remain % 3))
        urlpd_pkg::SLOT_HI: hi_nib = digit_value(c);
        urlpd_pkg::SLOT_LO: begin
          b     = {hi_nib, digit_value(c)};
          accum = {accum[urlpd_pkg::ChW-7:0], b[5:0]};
        end
        default: ;
      endcase
      if (remain == 1) begin
        pos  = urlpd_pkg::SEQ_IDLE;
        emit = 1'b1;
        if (lead[7:3] == 5'h1F) begin
          res.bad_lead = 1'b1;
        end else begin
          res.code_point = accum;
        end
      end else begin
        pos = pos - 1'b1;
      end
    end else begin
      pos = urlpd_pkg::SEQ_IDLE;
      if (c == urlpd_pkg::ChPercent) begin
        pos = urlpd_pkg::SEQ_HI;
      end else if (c == urlpd_pkg::ChPlus) begin
        emit           = 1'b1;
        res.code_point = urlpd_pkg::ChSpace;
      end else begin
        emit           = 1'b1;
        res.code_point = c;
      end
    end
    if (last) begin
      pos    = urlpd_pkg::SEQ_IDLE;
      lead   = '0;
      hi_nib = '0;
      accum  = '0;
    end
  endtask

  task automatic report_mismatch(input string field,
                                 input logic [urlpd_pkg::TdataW-1:0] want,
                                 input logic [urlpd_pkg::TdataW-1:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, field, want, got);
    fail_count_o++;
  endtask

  task automatic check_code_point();
    urlpd_pkg::result_t want;
    checked_o++;
    if (code_point_q.size() == 0) begin
      report_mismatch("unexpected item", '0, m_tdata_i);
      return;
    end
    want = code_point_q.pop_front();
    if (want.bad_lead) bad_count_o++;
    if (m_tdata_i !== {{(urlpd_pkg::TdataW-urlpd_pkg::ChW){1'b0}}, want.code_point}) begin
      report_mismatch("code_point", urlpd_pkg::TdataW'(want.code_point), m_tdata_i);
    end
    if (m_tuser_i !== want.bad_lead) begin
      report_mismatch("bad_lead", urlpd_pkg::TdataW'(want.bad_lead),
                      urlpd_pkg::TdataW'(m_tuser_i));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pos    = urlpd_pkg::SEQ_IDLE;
      lead   = '0;
      hi_nib = '0;
      accum  = '0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_code_point();
      if (s_tvalid_i && s_tready_i) begin
        decode_char(s_tdata_i[urlpd_pkg::ChW-1:0], s_tlast_i, got_one, next_res);
        if (got_one) code_point_q.push_back(next_res);
      end
    end
    pending_o = code_point_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives percent-encoded character strings into the decoder with random
// gaps and output stalls, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 450;
  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned DrainCycles = 10;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [urlpd_pkg::TdataW-1:0] s_tdata;
  logic                         s_tlast;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [urlpd_pkg::TdataW-1:0] m_tdata;
  logic                         m_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned bad_count;

  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned strings = 0;
  bit          gap_en = 1'b1;
  bit          stall_en = 1'b1;

  logic [urlpd_pkg::ChW-1:0] word_q[$];

  always #6 clk_i = ~clk_i;

  url_percent_utf8_decoder_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  urlpd_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .bad_count_o  (bad_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAIL url_percent_utf8_decoder_core");
      $finish;
    end
  end

  // accept results with a random stall before each one
  initial begin
    int unsigned stall;
    m_tready <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = stall_en ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  function automatic logic [urlpd_pkg::ChW-1:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return urlpd_pkg::ChW'(21'h30 + n);
    return ($urandom_range(0, 1) ? urlpd_pkg::ChW'(21'h61) : urlpd_pkg::ChW'(21'h41))
           + urlpd_pkg::ChW'(n) - urlpd_pkg::ChW'(10);
  endfunction

  function automatic logic [urlpd_pkg::ChW-1:0] any_char();
    return urlpd_pkg::ChW'($urandom_range(0, 21'h10FFFF));
  endfunction

  // push one %XY group; with noise, corrupt the slots now and then
  task automatic push_pct_byte(input logic [7:0] b, input bit noisy);
    word_q.push_back((noisy && $urandom_range(0, 7) == 0) ? any_char()
                                                          : urlpd_pkg::ChPercent);
    word_q.push_back((noisy && $urandom_range(0, 15) == 0) ? any_char() : hex_char(b[7:4]));
    word_q.push_back((noisy && $urandom_range(0, 15) == 0) ? any_char() : hex_char(b[3:0]));
  endtask

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [urlpd_pkg::ChW-1:0] c, input logic last);
    int unsigned gap;
    gap = gap_en ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(urlpd_pkg::TdataW-urlpd_pkg::ChW){1'b0}}, c};
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_word(input bit ends);
    for (int i = 0; i < word_q.size(); i++) begin
      send_char(word_q[i], ends && (i == word_q.size() - 1));
    end
    word_q.delete();
    if (ends) strings++;
  endtask

  task automatic build_token(output bit ends);
    int unsigned kind;
    int unsigned width;
    int unsigned len;
    logic [7:0]  lead;
    logic [7:0]  cont;
    logic [7:0]  r;
    logic [urlpd_pkg::ChW-1:0] c;
    kind = $urandom_range(0, 9);
    ends = ($urandom_range(0, 5) == 0);
    r    = 8'($urandom);
    if (kind <= 2) begin
      case ($urandom_range(0, 7))
        0: c = urlpd_pkg::ChPlus;
        1: c = any_char();
        default: begin
          c = urlpd_pkg::ChW'($urandom_range(32, 126));
          if (c == urlpd_pkg::ChPercent) c = urlpd_pkg::ChPlus;
        end
      endcase
      word_q.push_back(c);
    end else if (kind <= 8) begin
      width = $urandom_range(0, 5);
      case (width)
        0: lead = 8'($urandom_range(0, 8'hBF));
        1: lead = 8'hC0 | {3'b000, r[4:0]};
        2: lead = 8'hE0 | {4'b0000, r[3:0]};
        3: lead = 8'hF0 | {5'b00000, r[2:0]};
        4: lead = 8'hF8 | {6'b000000, r[1:0]};
        default: lead = 8'hFC | {7'b0000000, r[0]};
      endcase
      word_q.push_back(urlpd_pkg::ChPercent);
      word_q.push_back(hex_char(lead[7:4]));
      word_q.push_back(hex_char(lead[3:0]));
      for (int g = 0; g < width; g++) begin
        cont = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h80 | 8'($urandom_range(0, 63));
        push_pct_byte(cont, 1'b1);
      end
    end else begin
      // noise always closes its string so later sequences start clean
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0: c = urlpd_pkg::ChPercent;
          1: c = hex_char(4'($urandom));
          2: c = urlpd_pkg::ChPlus;
          default: c = any_char();
        endcase
        word_q.push_back(c);
      end
      ends = 1'b1;
    end
  endtask

  initial begin
    bit          ends;
    int unsigned cut;
    int unsigned phase_left;
    int unsigned mode;
    rst_ni   = 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, plus, single-byte escape, 2- and 3-byte, cut-off sequence
    word_q = {urlpd_pkg::ChPlus, urlpd_pkg::ChW'(0), urlpd_pkg::ChW'(21'h10FFFF)};
    send_word(1'b0);
    push_pct_byte(8'h41, 1'b0);
    send_word(1'b0);
    push_pct_byte(8'hC3, 1'b0);
    push_pct_byte(8'hA9, 1'b0);
    send_word(1'b0);
    push_pct_byte(8'hE2, 1'b0);
    push_pct_byte(8'h82, 1'b0);
    push_pct_byte(8'hAC, 1'b0);
    send_word(1'b0);
    push_pct_byte(8'hC3, 1'b0);
    word_q.push_back(urlpd_pkg::ChPercent);
    send_word(1'b1);

    phase_left = 0;
    while (items_sent < RandomItems + 25) begin
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        gap_en     = mode[0];
        stall_en   = mode[1];
        phase_left = 30;
      end
      phase_left--;
      build_token(ends);
      if (ends && word_q.size() > 1 && $urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, word_q.size() - 1);
        while (word_q.size() > cut) void'(word_q.pop_back());
      end
      send_word(ends);
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("sent %0d characters in %0d strings, including truncated and corrupt sequences",
             items_sent, strings);
    $display("checked %0d code points, %0d of them bad 5- or 6-byte leads", checked, bad_count);
    if (fail_count == 0) begin
      $display("PASS url_percent_utf8_decoder_core");
    end else begin
      $display("FAIL url_percent_utf8_decoder_core");
    end
    $finish;
  end

endmodule
